// ===== design/pfq_pkg.sv =====
// Shared types, constants and compare functions for the priority/FIFO job queue.
`timescale 1ns / 1ps
`default_nettype none

package pfq_pkg;

  localparam int TAG_W     = 16;
  localparam int PRIO_W    = 8;
  localparam int SEQ_W     = 32;
  localparam int CNT_OUT_W = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_SCAN,
    S_POP_SCAN,
    S_POP_LAST,
    S_POP_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [TAG_W-1:0]  job_tag;
    logic [PRIO_W-1:0] job_priority;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 popped_valid;
    logic [TAG_W-1:0]     popped_tag;
    logic [PRIO_W-1:0]    popped_priority;
    logic [SEQ_W-1:0]     assigned_sequence;
    logic [CNT_OUT_W-1:0] pending_count;
  } out_item_t;

  // One stored job as it sits in the entry RAM.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Serial-number order: a is strictly older than b.
  function automatic logic is_older(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

  // True when candidate c is served before the current best b.
  function automatic logic is_better(logic policy, entry_t c, entry_t b);
    logic res;
    if (policy && (c.prio != b.prio)) begin
      res = (c.prio > b.prio);
    end else begin
      res = is_older(c.seq, b.seq);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/pfq_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; read data is registered, so it appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== design/pfq_engine.sv =====
// Queue engine: sequencer, valid bits, counters and the scanning comparator.
`timescale 1ns / 1ps
`default_nettype none

module pfq_engine #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                policy,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pfq_pkg::in_item_t   in_data,
  output logic                     res_valid,
  input  wire logic                res_take,
  output pfq_pkg::out_item_t       res
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  pfq_pkg::state_t state, state_next;

  logic [IDX_W-1:0]                idx;
  logic [QUEUE_DEPTH-1:0]          valid_bits;
  logic [CNT_W-1:0]                count;
  logic [pfq_pkg::SEQ_W-1:0]       seq_ctr;
  logic [pfq_pkg::TAG_W-1:0]       cur_tag;
  logic [pfq_pkg::PRIO_W-1:0]      cur_prio;
  logic                            rd_pend;
  logic                            rd_live;
  logic [IDX_W-1:0]                rd_slot;
  logic                            best_have;
  logic [IDX_W-1:0]                best_slot;
  pfq_pkg::entry_t                 best;
  logic                            mem_we;
  pfq_pkg::entry_t                 mem_wdata;
  pfq_pkg::entry_t                 mem_rdata;
  logic [CNT_W-1:0]                count_inc;
  logic [CNT_W-1:0]                count_dec;

  assign count_inc = count + 1'b1;
  assign count_dec = count - 1'b1;
  assign mem_wdata = '{tag: cur_tag, prio: cur_prio, seq: seq_ctr};

  // Entry storage: one job per slot, read back one slot per cycle during a pop.
  pfq_ram #(
    .WIDTH (pfq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (idx),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    unique case (state)
      pfq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.operation == pfq_pkg::OP_PUSH) begin
            state_next = pfq_pkg::S_PUSH_SCAN;
          end else if (count == '0) begin
            state_next = pfq_pkg::S_DONE;
          end else begin
            state_next = pfq_pkg::S_POP_SCAN;
          end
        end
      end
      pfq_pkg::S_PUSH_SCAN: begin
        if (!valid_bits[idx]) begin
          mem_we     = 1'b1;
          state_next = pfq_pkg::S_DONE;
        end else if (idx == LAST_IDX) begin
          state_next = pfq_pkg::S_DONE;
        end
      end
      pfq_pkg::S_POP_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = pfq_pkg::S_POP_LAST;
        end
      end
      pfq_pkg::S_POP_LAST: begin
        state_next = pfq_pkg::S_POP_FIN;
      end
      pfq_pkg::S_POP_FIN: begin
        state_next = pfq_pkg::S_DONE;
      end
      pfq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = pfq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pfq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      count      <= '0;
      seq_ctr    <= '0;
      idx        <= '0;
      rd_pend    <= 1'b0;
      best_have  <= 1'b0;
    end else begin
      // Track the slot whose read data arrives next cycle.
      rd_pend <= (state == pfq_pkg::S_POP_SCAN);
      rd_slot <= idx;
      rd_live <= valid_bits[idx];

      // Keep the best live entry seen so far.
      if (rd_pend && rd_live && (!best_have || pfq_pkg::is_better(policy, mem_rdata, best))) begin
        best      <= mem_rdata;
        best_slot <= rd_slot;
        best_have <= 1'b1;
      end

      case (state)
        pfq_pkg::S_IDLE: begin
          if (in_valid) begin
            cur_tag   <= in_data.job_tag;
            cur_prio  <= in_data.job_priority;
            idx       <= '0;
            best_have <= 1'b0;
            res       <= '{status: pfq_pkg::STATUS_EMPTY, popped_valid: 1'b0,
                           popped_tag: '0, popped_priority: '0,
                           assigned_sequence: '0, pending_count: '0};
          end
        end
        pfq_pkg::S_PUSH_SCAN: begin
          if (!valid_bits[idx]) begin
            valid_bits[idx] <= 1'b1;
            count           <= count_inc;
            seq_ctr         <= seq_ctr + 1'b1;
            res <= '{status: pfq_pkg::STATUS_OK, popped_valid: 1'b0,
                     popped_tag: '0, popped_priority: '0,
                     assigned_sequence: seq_ctr,
                     pending_count: pfq_pkg::CNT_OUT_W'(count_inc)};
          end else if (idx == LAST_IDX) begin
            res <= '{status: pfq_pkg::STATUS_FULL, popped_valid: 1'b0,
                     popped_tag: '0, popped_priority: '0,
                     assigned_sequence: '0,
                     pending_count: pfq_pkg::CNT_OUT_W'(count)};
          end else begin
            idx <= idx + 1'b1;
          end
        end
        pfq_pkg::S_POP_SCAN: begin
          if (idx != LAST_IDX) begin
            idx <= idx + 1'b1;
          end
        end
        pfq_pkg::S_POP_FIN: begin
          valid_bits[best_slot] <= 1'b0;
          count                 <= count_dec;
          res <= '{status: pfq_pkg::STATUS_OK, popped_valid: 1'b1,
                   popped_tag: best.tag, popped_priority: best.prio,
                   assigned_sequence: best.seq,
                   pending_count: pfq_pkg::CNT_OUT_W'(count_dec)};
        end
        default: begin
        end
      endcase
    end
  end

  // The held count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("held count exceeds queue depth");

  // The held count always matches the number of occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid_bits)) == count)
    else $error("held count disagrees with valid bits");

  // A pop that reaches its final step has found a live entry.
  a_pop_found: assert property (@(posedge clk) disable iff (rst)
    state == pfq_pkg::S_POP_FIN |-> best_have && valid_bits[best_slot])
    else $error("pop finished without a live best entry");

  // The removed slot is free after the pop completes.
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    state == pfq_pkg::S_POP_FIN |=> !valid_bits[$past(best_slot)])
    else $error("popped slot still marked valid");

endmodule

`default_nettype wire

// ===== design/priority_fifo_job_queue_top.sv =====
// Top level of the priority/FIFO job queue: policy register, engine and output register.
// Push: the result follows a slot-by-slot search for a free slot.
// Pop: every RAM entry is read, one per cycle, before the best entry is removed.
// A pop on an empty queue goes straight to the result. One item is in the engine at a time.
// The output register frees the engine on handover; the next transfer can follow in the cycle after.
// Reset clears valid bits, count, sequence counter and policy; the entry RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module priority_fifo_job_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pfq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pfq_pkg::out_item_t      out_data
);

  logic               policy_mode;
  logic               res_valid;
  logic               res_take;
  pfq_pkg::out_item_t res;

  // Selection policy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 1'b0;
    end else if (cfg_we) begin
      policy_mode <= cfg_wdata;
    end
  end

  pfq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy_mode),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register takes a result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the priority/FIFO job queue top level.
`timescale 1ns / 1ps

module testbench;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_JOBS = 255;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pfq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pfq_pkg::out_item_t out_data;

  // Jobs waiting to be driven and results waiting to come back.
  pfq_pkg::in_item_t  pending_jobs[$];
  pfq_pkg::out_item_t expected_results[$];

  // Shadow copy of the queue contents and the selection policy.
  bit                         slot_used[QUEUE_DEPTH];
  logic [pfq_pkg::TAG_W-1:0]  slot_tag[QUEUE_DEPTH];
  logic [pfq_pkg::PRIO_W-1:0] slot_prio[QUEUE_DEPTH];
  logic [pfq_pkg::SEQ_W-1:0]  slot_seq[QUEUE_DEPTH];
  logic [pfq_pkg::SEQ_W-1:0]  next_stamp = '0;
  int                         held_jobs = 0;
  bit                         serve_by_priority = 1'b0;

  // Run bookkeeping.
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  n_jobs = 0;
  int  n_stored = 0;
  int  n_served = 0;
  int  n_refused = 0;
  int  n_empty_pops = 0;
  int  n_checked = 0;
  int  n_policy_writes = 0;
  bit  in_sent = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;

  priority_fifo_job_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Slot a is served before slot b under the current policy.
  function automatic bit goes_first(int a, int b);
    logic [pfq_pkg::SEQ_W-1:0] age_gap;
    if (serve_by_priority && slot_prio[a] != slot_prio[b]) begin
      return slot_prio[a] > slot_prio[b];
    end
    // Serial-number order: a is older when b - a is nonzero and below half the range.
    age_gap = slot_seq[b] - slot_seq[a];
    return (age_gap != '0) && !age_gap[pfq_pkg::SEQ_W-1];
  endfunction

  // Apply one job to the shadow queue and return the result it should produce.
  function automatic pfq_pkg::out_item_t predict_job(pfq_pkg::in_item_t job);
    pfq_pkg::out_item_t res;
    int                 slot;
    int                 i;
    res = '0;
    res.status = pfq_pkg::STATUS_OK;
    slot = -1;
    n_jobs++;
    if (job.operation == pfq_pkg::OP_PUSH) begin
      // The lowest-numbered free slot takes the job.
      for (i = QUEUE_DEPTH - 1; i >= 0; i--) begin
        if (!slot_used[i]) slot = i;
      end
      if (slot < 0) begin
        res.status = pfq_pkg::STATUS_FULL;
        n_refused++;
      end else begin
        slot_used[slot] = 1'b1;
        slot_tag[slot] = job.job_tag;
        slot_prio[slot] = job.job_priority;
        slot_seq[slot] = next_stamp;
        res.assigned_sequence = next_stamp;
        next_stamp = next_stamp + 1'b1;
        held_jobs++;
        n_stored++;
      end
    end else begin
      for (i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_used[i] && (slot < 0 || goes_first(i, slot))) slot = i;
      end
      if (slot < 0) begin
        res.status = pfq_pkg::STATUS_EMPTY;
        n_empty_pops++;
      end else begin
        res.popped_valid = 1'b1;
        res.popped_tag = slot_tag[slot];
        res.popped_priority = slot_prio[slot];
        res.assigned_sequence = slot_seq[slot];
        slot_used[slot] = 1'b0;
        held_jobs--;
        n_served++;
      end
    end
    res.pending_count = held_jobs[pfq_pkg::CNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  function automatic void add_job(pfq_pkg::op_t op, logic [pfq_pkg::TAG_W-1:0] tag,
                                  logic [pfq_pkg::PRIO_W-1:0] prio);
    pfq_pkg::in_item_t job;
    job.operation = op;
    job.job_tag = tag;
    job.job_priority = prio;
    pending_jobs = {pending_jobs, job};
  endfunction

  // Wait until every job is taken and every result has come back.
  task automatic wait_drained();
    while (pending_jobs.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (QUEUE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_policy(logic mode);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_policy_writes++;
  endtask

  // Input driver: holds each job until its transfer, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_sent) begin
      in_sent = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_jobs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
        in_gap = $urandom_range(1, 15) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_jobs[0];
      end
    end
  end

  // Result receiver: ready with random stall bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: tracks the policy, predicts on each input transfer, checks each output transfer.
  always @(posedge clk) begin
    pfq_pkg::out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
    if (!rst) begin
      if (cfg_we) serve_by_priority = cfg_wdata;
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_job(in_data)};
        pending_jobs.delete(0);
        in_sent = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected nothing, actual %0h",
                   $time, out_data);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          n_checked++;
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("popped_valid", 32'(want.popped_valid), 32'(out_data.popped_valid));
          check_field("popped_tag", 32'(want.popped_tag), 32'(out_data.popped_tag));
          check_field("popped_priority", 32'(want.popped_priority),
                      32'(out_data.popped_priority));
          check_field("assigned_sequence", want.assigned_sequence,
                      out_data.assigned_sequence);
          check_field("pending_count", 32'(want.pending_count), 32'(out_data.pending_count));
        end
      end
    end
  end

  // Stimulus: a directed opening, then random phases under a fixed mix of both policies.
  initial begin
    logic [pfq_pkg::TAG_W-1:0]  fill_tags[QUEUE_DEPTH];
    logic [pfq_pkg::PRIO_W-1:0] fill_prios[QUEUE_DEPTH];
    logic                       phase_policy[RANDOM_PHASES];
    pfq_pkg::in_item_t          job;
    int                         push_pct;
    int                         prio_top;
    int                         p;
    int                         n;
    fill_tags = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'haaaa, 16'h5555,
                  16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0, 16'h1234, 16'hfedc, 16'h3c3c,
                  16'hc3c3, 16'h8001};
    fill_prios = '{8'd0, 8'd255, 8'd7, 8'd255, 8'd128, 8'd127, 8'd7, 8'd1, 8'd254, 8'd0,
                   8'd64, 8'd255, 8'd2, 8'd7, 8'd200, 8'd128};
    phase_policy = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    push_pct = 50;
    prio_top = 255;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Oldest-first: pop on an empty queue, fill to the brim, then a push that is refused.
    write_policy(1'b0);
    add_job(pfq_pkg::OP_POP, 16'h5a5a, 8'ha5);
    for (n = 0; n < QUEUE_DEPTH; n++) add_job(pfq_pkg::OP_PUSH, fill_tags[n], fill_prios[n]);
    add_job(pfq_pkg::OP_PUSH, 16'hdead, 8'hff);
    wait_drained();

    // Priority order on the full queue, with ties among the top priorities.
    write_policy(1'b1);
    for (n = 0; n < 4; n++) add_job(pfq_pkg::OP_POP, 16'hffff, 8'hff);
    add_job(pfq_pkg::OP_PUSH, 16'h0f0f, 8'd128);
    add_job(pfq_pkg::OP_POP, 16'h0000, 8'h00);
    wait_drained();

    // Random phases; the load swings between mostly pops and mostly pushes.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_policy(phase_policy[p]);
      if (p == RANDOM_PHASES - 1) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = $urandom_range(0, 25);
        out_idle_pct = $urandom_range(0, 25);
      end
      for (n = 0; n < PHASE_JOBS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 3))
            0: push_pct = 20;
            1: push_pct = 50;
            2: push_pct = 75;
            default: push_pct = 95;
          endcase
          // Narrow priority ranges force ties that fall back to age order.
          prio_top = $urandom_range(0, 1) ? 255 : 3;
        end
        job.operation = ($urandom_range(0, 99) < push_pct) ? pfq_pkg::OP_PUSH : pfq_pkg::OP_POP;
        job.job_tag = 16'($urandom_range(0, 16'hffff));
        job.job_priority = 8'($urandom_range(0, prio_top));
        pending_jobs = {pending_jobs, job};
      end
      wait_drained();
    end

    $display("Covered %0d jobs: %0d stored, %0d served, %0d refused when full, %0d empty pops.",
             n_jobs, n_stored, n_served, n_refused, n_empty_pops);
    $display("%0d results checked over %0d policy writes, both oldest-first and priority order.",
             n_checked, n_policy_writes);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
